>>> hdl/lpfr_pkg.sv
`timescale 1ns / 1ps
package lpfr_pkg;

    localparam int FRAMES  = 8;
    localparam int SLOT_W  = 3;
    localparam int RANK_W  = 3;
    localparam int PAGE_W  = 16;
    localparam int CNT_W   = 4;
    localparam int FAULT_W = 32;
    localparam int ODATA_W = 40;

    localparam logic [CNT_W-1:0]   FRAMES_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX    = {FAULT_W{1'b1}};

    // Search state handed from one cell to the next
    typedef struct packed {
        logic              hit_found;
        logic [SLOT_W-1:0] hit_slot;
        logic [RANK_W-1:0] hit_rank;
        logic              empty_found;
        logic [SLOT_W-1:0] empty_slot;
        logic [RANK_W-1:0] max_rank;
        logic [SLOT_W-1:0] max_slot;
    } lpfr_chain_t;

    // Update broadcast to every cell
    typedef struct packed {
        logic              en;
        logic              fill;
        logic [SLOT_W-1:0] slot;
        logic [RANK_W-1:0] limit;
        logic [PAGE_W-1:0] page;
    } lpfr_upd_t;

endpackage

>>> hdl/lru_page_frame_replacer_unit.sv
`timescale 1ns / 1ps
// LRU page frame replacer.
// Input channel s_*: one word per page reference, s_tdata holds the page
// number. Result channel m_*: one word per reference, m_tuser is the hit
// flag, m_tdata holds the frame slot used and the running fault total.
// cfg_we/cfg_wdata set the number of frames in use (1..8, 0 acts as 1,
// above 8 acts as 8); write it only while the block is idle.
// A word accepted on s_* is registered in page_reg. Once the result register
// is free it is searched and applied, and its result is registered and shows
// on m_tvalid. Throughput: one word per cycle while m_tready stays high. The
// search ripples through a row of eight frame cells within the processing
// cycle, and the chosen frame's update is broadcast back to all cells at its end.
// Reset: all frames empty, all ranks zero, fault count zero, eight frames
// in use. The result register is empty after reset.
// Stall: while m_tready is low with a result waiting, one more word is
// taken and held; s_tready then drops until the result is taken.
module lru_page_frame_replacer_unit
    import lpfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,   // [3:0] frames_in_use
    // input channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PAGE_W-1:0]  s_tdata,     // [15:0] page_number
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ODATA_W-1:0] m_tdata,     // [2:0] frame_slot, [34:3] fault_total, rest 0
    output logic               m_tuser      // [0] hit
);

    logic [CNT_W-1:0]   frames_reg;
    logic [CNT_W-1:0]   n_eff;
    logic               busy_reg, busy_next;
    logic [PAGE_W-1:0]  page_reg;
    logic               m_valid_reg, m_valid_next;
    logic               hit_out_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic               s_accept;
    logic               process;
    logic [FRAMES-1:0]  active;
    lpfr_chain_t        chain [FRAMES+1];
    lpfr_chain_t        found;
    lpfr_upd_t          upd;
    logic [SLOT_W-1:0]  slot;

    // Handshake: process the held word when the result register is free
    assign process  = busy_reg && (!m_valid_reg || m_tready);
    assign s_tready = !busy_reg || process;
    assign s_accept = s_tvalid && s_tready;

    // Clamp the frame count into 1..FRAMES
    always_comb begin
        n_eff = frames_reg;
        if (frames_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (frames_reg > CNT_W'(FRAMES)) begin
            n_eff = CNT_W'(FRAMES);
        end
    end

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_cell
            assign active[g] = (CNT_W'(g) < n_eff);
            lpfr_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (SLOT_W'(g)),
                .active   (active[g]),
                .page     (page_reg),
                .chain_in (chain[g]),
                .chain_out(chain[g+1]),
                .upd      (upd)
            );
        end
    endgenerate

    assign found = chain[FRAMES];

    // Pick the frame: hit, else first empty, else least recently used
    always_comb begin
        upd.en   = process;
        upd.page = page_reg;
        upd.fill = 1'b0;
        if (found.hit_found) begin
            slot      = found.hit_slot;
            upd.limit = found.hit_rank;
        end else if (found.empty_found) begin
            slot      = found.empty_slot;
            upd.limit = '0;
            upd.fill  = 1'b1;
        end else begin
            slot      = found.max_slot;
            upd.limit = found.max_rank;
        end
        upd.slot = slot;
    end

    // Count faults, hold at the top
    always_comb begin
        fault_next = fault_reg;
        if (process && !found.hit_found && (fault_reg != FAULT_MAX)) begin
            fault_next = fault_reg + FAULT_W'(1);
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (s_accept) begin
            busy_next = 1'b1;
        end else if (process) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (process) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg  <= FRAMES_RESET;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            fault_reg   <= '0;
        end else begin
            if (cfg_we) begin
                frames_reg <= cfg_wdata;
            end
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            fault_reg   <= fault_next;
        end
    end

    // Payload registers: hold the page and the result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            page_reg <= s_tdata;
        end
        if (process) begin
            hit_out_reg  <= found.hit_found;
            slot_out_reg <= slot;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_out_reg;
    assign m_tdata  = {{(ODATA_W-FAULT_W-SLOT_W){1'b0}}, fault_reg, slot_out_reg};

`ifndef SYNTH
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> m_valid_reg && (m_tuser == $past(found.hit_found)))
        else $error("processed word did not reach the result register");

    a_slot_active: assert property (@(posedge aclk) disable iff (!aresetn)
        process |-> ({1'b0, slot} < n_eff))
        else $error("chosen frame lies outside the frames in use");

    a_fault_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (fault_reg >= $past(fault_reg)))
        else $error("fault count went down");

    a_hit_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && found.hit_found) |=> (fault_reg == $past(fault_reg)))
        else $error("fault count moved on a hit");
`endif

endmodule

>>> hdl/lpfr_cell.sv
`timescale 1ns / 1ps
module lpfr_cell
    import lpfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] cell_idx,
    input  logic              active,
    input  logic [PAGE_W-1:0] page,
    input  lpfr_chain_t       chain_in,
    output lpfr_chain_t       chain_out,
    input  lpfr_upd_t         upd
);

    logic [PAGE_W-1:0] page_reg;
    logic              valid_reg, valid_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              match;
    logic              selected;

    assign match    = active && valid_reg && (page_reg == page);
    assign selected = (cell_idx == upd.slot);

    // Extend the search: first hit, first empty, oldest rank
    always_comb begin
        chain_out = chain_in;
        if (!chain_in.hit_found && match) begin
            chain_out.hit_found = 1'b1;
            chain_out.hit_slot  = cell_idx;
            chain_out.hit_rank  = rank_reg;
        end
        if (!chain_in.empty_found && active && !valid_reg) begin
            chain_out.empty_found = 1'b1;
            chain_out.empty_slot  = cell_idx;
        end
        if (active && (rank_reg > chain_in.max_rank)) begin
            chain_out.max_rank = rank_reg;
            chain_out.max_slot = cell_idx;
        end
    end

    // Selected frame becomes most recent; younger valid frames age by one, all other valid frames on a fill
    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.en) begin
            if (selected) begin
                valid_next = 1'b1;
                rank_next  = '0;
            end else if (valid_reg && (upd.fill || (rank_reg < upd.limit))) begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.en && selected) begin
            page_reg <= upd.page;
        end
    end

endmodule

>>> test/lru_frame_lookup_checker.sv
`timescale 1ns / 1ps
module lru_frame_lookup_checker
    import lpfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [PAGE_W-1:0]  s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [ODATA_W-1:0] m_tdata,
    input  logic               m_tuser,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [FAULT_W-1:0] faults;
    } lookup_result_t;

    lookup_result_t    expected_q [$];

    // Shadow copy of the frame table
    logic [PAGE_W-1:0] page_tbl [FRAMES];
    bit                resident [FRAMES];
    logic [RANK_W-1:0] age      [FRAMES];
    logic [FAULT_W-1:0] fault_cnt;
    logic [CNT_W-1:0]  frames_reg;

    // Make frame f the youngest; valid frames younger than limit age by one
    function automatic void make_recent(input int f, input int limit);
        for (int j = 0; j < FRAMES; j++) begin
            if (j != f && resident[j] && age[j] < limit)
                age[j] = age[j] + 1'b1;
        end
        age[f] = '0;
    endfunction

    function automatic lookup_result_t lookup_page(input logic [PAGE_W-1:0] pg);
        lookup_result_t r;
        int n;
        int oldest;
        bit found;
        r = '0;
        found = 1'b0;
        n = (frames_reg == 0) ? 1 : (frames_reg > FRAMES) ? FRAMES : int'(frames_reg);
        // lowest matching frame wins
        for (int j = 0; j < n && !found; j++) begin
            if (resident[j] && page_tbl[j] == pg) begin
                found  = 1'b1;
                r.slot = SLOT_W'(j);
            end
        end
        if (found) begin
            r.hit = 1'b1;
            make_recent(r.slot, age[r.slot]);
        end else begin
            if (fault_cnt != FAULT_MAX)
                fault_cnt = fault_cnt + 1'b1;
            for (int j = 0; j < n && !found; j++) begin
                if (!resident[j]) begin
                    found  = 1'b1;
                    r.slot = SLOT_W'(j);
                end
            end
            if (found) begin
                make_recent(r.slot, 255);
                resident[r.slot] = 1'b1;
            end else begin
                oldest = 0;
                r.slot = '0;
                for (int j = 0; j < n; j++) begin
                    if (age[j] > oldest) begin
                        oldest = age[j];
                        r.slot = SLOT_W'(j);
                    end
                end
                make_recent(r.slot, age[r.slot]);
            end
            page_tbl[r.slot] = pg;
        end
        r.faults = fault_cnt;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s wrong, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            for (int j = 0; j < FRAMES; j++) begin
                page_tbl[j] = '0;
                resident[j] = 1'b0;
                age[j]      = '0;
            end
            fault_cnt  = '0;
            frames_reg = FRAMES_RESET;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word with none expected, actual hit %0b slot %0d",
                             $time, m_tuser, m_tdata[SLOT_W-1:0]);
                end else begin
                    want = expected_q.pop_front();
                    check_field("hit", want.hit, m_tuser);
                    check_field("frame_slot", want.slot, m_tdata[SLOT_W-1:0]);
                    check_field("fault_total", want.faults, m_tdata[SLOT_W +: FAULT_W]);
                    check_field("pad bits", 0, m_tdata[ODATA_W-1:SLOT_W+FAULT_W]);
                end
            end
            if (cfg_we)
                frames_reg = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_q.push_back(lookup_page(s_tdata));
        end
        outstanding = expected_q.size();
    end

endmodule

>>> test/tb_lru_page_frame_replacer_unit.sv
`timescale 1ns / 1ps
module tb_lru_page_frame_replacer_unit;
    import lpfr_pkg::*;

    // Generous bound: roughly 1100 words plus drains
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 104;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [PAGE_W-1:0]  s_tdata;     // [15:0] page_number
    logic               m_tvalid;
    logic               m_tready;
    logic [ODATA_W-1:0] m_tdata;     // [2:0] frame_slot, [34:3] fault_total, rest 0
    logic               m_tuser;     // [0] hit

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit stall_en    = 1'b1;          // clear for a stretch with no idling on either side

    // Frame counts per random phase: both extremes, out-of-range values, and a spread
    logic [CNT_W-1:0] phase_frames [PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3,
                                                4'd5, 4'd2, 4'd12, 4'd7, 4'd6};

    lru_page_frame_replacer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    lru_frame_lookup_checker u_lookup_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Give up on a hang: a lost result or a stuck handshake ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: drop m_tready at random about 13 percent of the time while stall_en is set, once out of reset
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= stall_en ? ($urandom_range(99) >= 13) : 1'b1;
    end

    // Offer one page word, idling first at random, and hold it until it is taken.
    // Returns just after the accepting edge.
    task automatic send_page(input logic [PAGE_W-1:0] pg);
        @(negedge aclk);
        while (stall_en && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pg;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Drop valid and hold off until every expected result word has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    // Change the frame count only with the block idle
    task automatic write_frames(input logic [CNT_W-1:0] count);
        drain_results();
        cfg_wdata <= count;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [PAGE_W-1:0] base;
        int spread;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: fill from empty with the extreme pages, hit, then evict the oldest
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h0003);
        send_page(16'h0004);
        send_page(16'h0005);

        // Shrink to two frames: the upper frames sit out, page 1 lands again below
        write_frames(4'd2);
        send_page(16'h0007);
        send_page(16'h0001);

        // Grow back: page 1 now lives twice, the lower frame must win
        write_frames(4'd8);
        send_page(16'h0001);
        send_page(16'h0007);

        // Zero frames acts as one
        write_frames(4'd0);
        send_page(16'h0009);
        send_page(16'h0009);
        send_page(16'h000A);

        // Above the frame count acts as all frames
        write_frames(4'd15);
        send_page(16'h000A);
        send_page(16'h000B);

        // Random phases: references cluster around a base so hits and evictions mix,
        // with some fully random pages to work every address bit
        for (int p = 0; p < PHASES; p++) begin
            write_frames(phase_frames[p]);
            stall_en = (p != 4);
            base     = PAGE_W'($urandom_range(16'hFFFF));
            spread   = $urandom_range(1, 14);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(99) < 15)
                    send_page(PAGE_W'($urandom_range(16'hFFFF)));
                else
                    send_page(base + PAGE_W'($urandom_range(spread)));
            end
        end
        stall_en = 1'b1;

        // Wait out the last results, then keep watching for any stray word
        drain_results();
        repeat (8) @(negedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> lru_page_frame_replacer_unit.f
hdl/lpfr_pkg.sv
hdl/lpfr_cell.sv
hdl/lru_page_frame_replacer_unit.sv
test/lru_frame_lookup_checker.sv
test/tb_lru_page_frame_replacer_unit.sv
